// ===== rtl/voxel_grid_ray_traversal_assert.svh =====
// Assertion macros for the voxel grid ray caster checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef VOXEL_GRID_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define VGRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define VGRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vgrt_pkg.sv =====
// Shared constants, state encoding and controller/datapath bundles
// for the voxel grid ray caster. No dependencies.
package vgrt_pkg;

  localparam int GRID_SIZE = 32;
  localparam int MAX_STEPS = 256;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CRD_W     = $clog2(GRID_SIZE);
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int CELL_W    = 22 + $clog2(MAX_STEPS);
  localparam int NUM_W     = 31;
  localparam int DEN_W     = 16;
  localparam int DCNT_W    = $clog2(NUM_W + 1);

  localparam logic [31:0] SAT = 32'hFFFF_FFFF;

  // Result status codes
  localparam logic [1:0] ST_WRITE = 2'd0;
  localparam logic [1:0] ST_HIT   = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_AX, S_TST, S_TWT, S_DST, S_DWT,
    S_SEL, S_SQ, S_M0, S_M1, S_CMP, S_RD, S_CHK, S_PUSH
  } state_t;

  typedef struct packed {
    logic       ready;
    logic       load;
    logic       clr;
    logic       wr;
    logic       mul_axis;
    logic       div_start;
    logic       div_delta;
    logic       store_tmax;
    logic       store_delta;
    logic       store_zero;
    logic       next_axis;
    logic       sel;
    logic       sq;
    logic       m0;
    logic       m1;
    logic       advance;
    logic       res_en;
    logic [1:0] res_code;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_ray;
    logic dir_zero;
    logic axis_zero;
    logic last_axis;
    logic div_done;
    logic beyond;
    logic solid;
    logic step_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/vgrt_in_if.sv =====
// Input channel of the voxel grid ray caster: valid/ready plus one item.
// No dependencies.
interface vgrt_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [4:0]         cell_x;
  logic [4:0]         cell_y;
  logic [4:0]         cell_z;
  logic               solid;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [31:0]        reach;

  modport source (output valid, kind, cell_x, cell_y, cell_z, solid, origin_x, origin_y,
                  origin_z, dir_x, dir_y, dir_z, reach, input ready);
  modport sink (input valid, kind, cell_x, cell_y, cell_z, solid, origin_x, origin_y,
                origin_z, dir_x, dir_y, dir_z, reach, output ready);
endinterface

// ===== rtl/vgrt_out_if.sv =====
// Result channel of the voxel grid ray caster: valid/ready plus one item.
// No dependencies.
interface vgrt_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [4:0]        hit_x;
  logic [4:0]        hit_y;
  logic [4:0]        hit_z;
  logic signed [1:0] normal_x;
  logic signed [1:0] normal_y;
  logic signed [1:0] normal_z;

  modport source (output valid, status, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, status, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                output ready);
endinterface

// ===== rtl/voxel_grid_ray_traversal.sv =====
// Voxel grid ray caster: a write item passes through the start and push states to the output
// register; a ray item runs a setup of two serial divides per moving axis, then steps each
// traversed cell through boundary select, the reach multiply chain and one occupancy read.
// One item in flight; the next is taken while a result waits in the output register.
// Synchronous reset starts a clearing pass over all 32768 cells of the occupancy memory,
// one cell a cycle, with no item accepted; configuration writes are taken throughout.
module voxel_grid_ray_traversal (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  vgrt_in_if.sink    in_ch,
  vgrt_out_if.source out_ch
);
  import vgrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vgrt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  vgrt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );
endmodule

// ===== rtl/vgrt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module vgrt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/vgrt_div.sv =====
// Restoring divider, one quotient bit per cycle, for ray setup.
// Depends on vgrt_pkg.
module vgrt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vgrt_pkg::NUM_W-1:0] num,
  input  logic [vgrt_pkg::DEN_W-1:0] den,
  output logic [vgrt_pkg::NUM_W-1:0] quo,
  output logic                       done
);
  import vgrt_pkg::*;

  logic [DEN_W:0]    rem;
  logic [DEN_W:0]    shifted;
  logic [DCNT_W-1:0] cnt;
  logic              busy;

  assign shifted = {rem[DEN_W-1:0], quo[NUM_W-1]};

  // Control: count the bits, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one numerator bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      if (shifted >= {1'b0, den}) begin
        rem <= shifted - {1'b0, den};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/vgrt_ctrl.sv =====
// Controller state machine of the voxel grid ray caster.
// Depends on vgrt_pkg; drives the datapath by command bundle only.
module vgrt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  vgrt_pkg::sts_t sts,
  output vgrt_pkg::cmd_t cmd
);
  import vgrt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:  if (sts.in_valid) state_next = S_START;
      S_START: begin
        if (!sts.is_ray || sts.dir_zero) state_next = S_PUSH;
        else state_next = S_AX;
      end
      S_AX: begin
        if (!sts.axis_zero) state_next = S_TST;
        else if (sts.last_axis) state_next = S_SEL;
      end
      S_TST: state_next = S_TWT;
      S_TWT: if (sts.div_done) state_next = S_DST;
      S_DST: state_next = S_DWT;
      S_DWT: begin
        if (sts.div_done) state_next = sts.last_axis ? S_SEL : S_AX;
      end
      S_SEL: state_next = S_SQ;
      S_SQ:  state_next = S_M0;
      S_M0:  state_next = S_M1;
      S_M1:  state_next = S_CMP;
      S_CMP: state_next = sts.beyond ? S_PUSH : S_RD;
      S_RD:  state_next = S_CHK;
      S_CHK: begin
        if (sts.solid || sts.step_last) state_next = S_PUSH;
        else state_next = S_SEL;
      end
      S_PUSH: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        cmd.ready = 1'b1;
        cmd.load  = sts.in_valid;
      end
      S_START: begin
        if (!sts.is_ray) begin
          cmd.wr       = 1'b1;
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_WRITE;
        end else if (sts.dir_zero) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_ZERO;
        end
      end
      S_AX: begin
        cmd.mul_axis   = 1'b1;
        cmd.store_zero = sts.axis_zero;
        cmd.next_axis  = sts.axis_zero;
      end
      S_TST: cmd.div_start = 1'b1;
      S_TWT: cmd.store_tmax = sts.div_done;
      S_DST: begin
        cmd.div_start = 1'b1;
        cmd.div_delta = 1'b1;
      end
      S_DWT: begin
        cmd.div_delta   = 1'b1;
        cmd.store_delta = sts.div_done;
        cmd.next_axis   = sts.div_done;
      end
      S_SEL: cmd.sel = 1'b1;
      S_SQ:  cmd.sq = 1'b1;
      S_M0:  cmd.m0 = 1'b1;
      S_M1:  cmd.m1 = 1'b1;
      S_CMP: begin
        if (sts.beyond) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_MISS;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_RD: cmd = '0;
      S_CHK: begin
        if (sts.solid) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_HIT;
        end else if (sts.step_last) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_MISS;
        end
      end
      S_PUSH: cmd.push = sts.out_free;
      default: cmd = '0;
    endcase
  end
endmodule

// ===== rtl/vgrt_datapath.sv =====
// Datapath of the voxel grid ray caster: item registers, axis setup,
// DDA stepping, reach test, occupancy memory and result register.
// Depends on vgrt_pkg, vgrt_in_if, vgrt_out_if, vgrt_ram and vgrt_div.
module vgrt_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_wdata,
  vgrt_in_if.sink        in_ch,
  vgrt_out_if.source     out_ch,
  input  vgrt_pkg::cmd_t cmd,
  output vgrt_pkg::sts_t sts
);
  import vgrt_pkg::*;

  localparam logic [NUM_W-1:0] DELTA_NUM = NUM_W'(32'h4000_0000);

  logic [4:0]               scale;
  logic                     is_ray;
  logic [4:0]               wx, wy, wz;
  logic                     wsolid;
  logic signed [31:0]       org [3];
  logic signed [15:0]       dir [3];
  logic [1:0]               ai, axs, ax_c;
  logic signed [CELL_W-1:0] vox [3];
  logic signed [1:0]        stp [3];
  logic [31:0]              tmax [3];
  logic [31:0]              delta [3];
  logic [15:0]              frac;
  logic [31:0]              sumsq;
  logic [63:0]              r2;
  logic [31:0]              tsel;
  logic [63:0]              p2, pl, ph;
  logic [STEP_W-1:0]        nstep;
  logic [ADDR_W-1:0]        clr_cnt;
  logic                     inside_q;

  logic signed [37:0]       adj;
  logic signed [31:0]       dsq;
  logic [DEN_W-1:0]         den;
  logic [16:0]              rem;
  logic [NUM_W-1:0]         num, quo;
  logic                     div_done;
  logic [32:0]              tsum;
  logic [95:0]              prod, rr;
  logic                     inside_c, wr_ok;
  logic [ADDR_W-1:0]        raddr, waddr_w, waddr;
  logic                     rdata, we, wdata;

  logic [1:0]               r_status;
  logic [4:0]               r_hx, r_hy, r_hz;
  logic signed [1:0]        r_nx, r_ny, r_nz;
  logic                     out_valid;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= 5'd1;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // Axis setup arithmetic
  assign adj = $signed(org[ai]) * $signed({1'b0, scale});
  assign dsq = dir[ai] * dir[ai];
  assign den = dir[ai][15] ? DEN_W'(-dir[ai]) : DEN_W'(dir[ai]);
  always_comb begin
    if (!dir[ai][15]) begin
      rem = 17'h1_0000 - {1'b0, frac};
    end else if (frac == 16'd0) begin
      rem = 17'h1_0000;
    end else begin
      rem = {1'b0, frac};
    end
  end
  assign num = cmd.div_delta ? DELTA_NUM : {rem, 14'd0};

  vgrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

  // Nearest boundary: z wins ties over x and y, y over x
  always_comb begin
    if (tmax[0] < tmax[1]) begin
      ax_c = (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
    end else begin
      ax_c = (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
    end
  end

  assign tsum = {1'b0, tmax[axs]} + {1'b0, delta[axs]};
  assign prod = {ph, 32'd0} + {32'd0, pl};
  assign rr   = {4'd0, r2, 28'd0};

  // Item, setup and stepping registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_ray <= in_ch.kind;
      wx     <= in_ch.cell_x;
      wy     <= in_ch.cell_y;
      wz     <= in_ch.cell_z;
      wsolid <= in_ch.solid;
      org[0] <= in_ch.origin_x;
      org[1] <= in_ch.origin_y;
      org[2] <= in_ch.origin_z;
      dir[0] <= in_ch.dir_x;
      dir[1] <= in_ch.dir_y;
      dir[2] <= in_ch.dir_z;
      r2     <= 64'(in_ch.reach) * 64'(in_ch.reach);
      sumsq  <= '0;
      ai     <= '0;
      nstep  <= '0;
    end
    if (cmd.mul_axis) begin
      vox[ai] <= CELL_W'($signed(adj[37:16]));
      frac    <= adj[15:0];
      sumsq   <= sumsq + 32'(dsq);
      if (dir[ai] == 16'sd0) begin
        stp[ai] <= 2'sd0;
      end else begin
        stp[ai] <= dir[ai][15] ? -2'sd1 : 2'sd1;
      end
    end
    if (cmd.store_zero) begin
      tmax[ai]  <= SAT;
      delta[ai] <= SAT;
    end
    if (cmd.store_tmax) begin
      tmax[ai] <= 32'(quo);
    end
    if (cmd.store_delta) begin
      delta[ai] <= 32'(quo);
    end
    if (cmd.next_axis) begin
      ai <= ai + 2'd1;
    end
    if (cmd.sel) begin
      axs  <= ax_c;
      tsel <= tmax[ax_c];
    end
    if (cmd.sq) begin
      p2 <= 64'(tsel) * 64'(tsel);
    end
    if (cmd.m0) begin
      pl <= 64'(p2[31:0]) * 64'(sumsq);
    end
    if (cmd.m1) begin
      ph <= 64'(p2[63:32]) * 64'(sumsq);
    end
    if (cmd.advance) begin
      vox[axs]  <= vox[axs] + CELL_W'(stp[axs]);
      tmax[axs] <= tsum[32] ? SAT : tsum[31:0];
      nstep     <= nstep + 1'b1;
    end
  end

  // Occupancy addressing: cells outside the grid read as empty
  always_comb begin
    inside_c = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (vox[i][CELL_W-1] || vox[i] >= $signed(CELL_W'(GRID_SIZE))) begin
        inside_c = 1'b0;
      end
    end
  end
  assign raddr = ADDR_W'(vox[0][CRD_W-1:0])
               + ADDR_W'(GRID_SIZE) * ADDR_W'(vox[1][CRD_W-1:0])
               + ADDR_W'(GRID_SIZE * GRID_SIZE) * ADDR_W'(vox[2][CRD_W-1:0]);
  assign wr_ok = (32'(wx) < GRID_SIZE) && (32'(wy) < GRID_SIZE) && (32'(wz) < GRID_SIZE);
  assign waddr_w = ADDR_W'(CRD_W'(wx))
                 + ADDR_W'(GRID_SIZE) * ADDR_W'(CRD_W'(wy))
                 + ADDR_W'(GRID_SIZE * GRID_SIZE) * ADDR_W'(CRD_W'(wz));
  assign we    = cmd.clr || (cmd.wr && wr_ok);
  assign waddr = cmd.clr ? clr_cnt : waddr_w;
  assign wdata = cmd.clr ? 1'b0 : wsolid;

  always_ff @(posedge clk) begin
    inside_q <= inside_c;
  end

  // Clearing pass sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  vgrt_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      r_status <= cmd.res_code;
      r_hx     <= '0;
      r_hy     <= '0;
      r_hz     <= '0;
      r_nx     <= 2'sd0;
      r_ny     <= 2'sd0;
      r_nz     <= 2'sd0;
      if (cmd.res_code == ST_HIT) begin
        r_hx <= vox[0][4:0];
        r_hy <= vox[1][4:0];
        r_hz <= vox[2][4:0];
        if (axs == 2'd0) r_nx <= -stp[0];
        if (axs == 2'd1) r_ny <= -stp[1];
        if (axs == 2'd2) r_nz <= -stp[2];
      end
    end
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_ch.status   <= r_status;
      out_ch.hit_x    <= r_hx;
      out_ch.hit_y    <= r_hy;
      out_ch.hit_z    <= r_hz;
      out_ch.normal_x <= r_nx;
      out_ch.normal_y <= r_ny;
      out_ch.normal_z <= r_nz;
    end
  end

  assign out_ch.valid = out_valid;
  assign in_ch.ready  = cmd.ready;

  // Status back to the controller
  assign sts.in_valid  = in_ch.valid;
  assign sts.is_ray    = is_ray;
  assign sts.dir_zero  = (dir[0] == 16'sd0) && (dir[1] == 16'sd0) && (dir[2] == 16'sd0);
  assign sts.axis_zero = (dir[ai] == 16'sd0);
  assign sts.last_axis = (ai == 2'd2);
  assign sts.div_done  = div_done;
  assign sts.beyond    = (prod > rr);
  assign sts.solid     = inside_q && rdata;
  assign sts.step_last = (nstep == STEP_W'(MAX_STEPS));
  assign sts.clr_last  = (clr_cnt == ADDR_W'(CELLS - 1));
  assign sts.out_free  = !out_valid || out_ch.ready;
endmodule

// ===== rtl/vgrt_chk.sv =====
// Port-level checker for the voxel grid ray caster, bound to the top level.
// Depends on vgrt_pkg and voxel_grid_ray_traversal_assert.svh.
`include "voxel_grid_ray_traversal_assert.svh"

module vgrt_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [4:0]        hit_x,
  input logic [4:0]        hit_y,
  input logic [4:0]        hit_z,
  input logic signed [1:0] normal_x,
  input logic signed [1:0] normal_y,
  input logic signed [1:0] normal_z
);
  import vgrt_pkg::*;

  // A stalled result stays offered
  `VGRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  // One item at a time: no second accept straight after the first
  `VGRT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken")

  // A hit names exactly one entered face
  `VGRT_ASSERT_NOW(a_hit_face, out_valid && status == ST_HIT, $onehot({normal_x != 2'sd0, normal_y != 2'sd0, normal_z != 2'sd0}), "hit normal")

  // Anything but a hit carries zero cell and normal
  `VGRT_ASSERT_NOW(a_no_hit_zero, out_valid && status != ST_HIT, hit_x == 5'd0 && hit_y == 5'd0 && hit_z == 5'd0 && normal_x == 2'sd0 && normal_y == 2'sd0 && normal_z == 2'sd0, "stray payload")
endmodule

bind voxel_grid_ray_traversal vgrt_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .hit_x     (out_ch.hit_x),
  .hit_y     (out_ch.hit_y),
  .hit_z     (out_ch.hit_z),
  .normal_x  (out_ch.normal_x),
  .normal_y  (out_ch.normal_y),
  .normal_z  (out_ch.normal_z)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the voxel grid ray caster: drives cell writes and ray casts,
// predicts every result with its own DDA model and checks the results in order.
// Depends on vgrt_pkg, vgrt_in_if, vgrt_out_if and voxel_grid_ray_traversal.
module tb_top;
  import vgrt_pkg::*;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_RAY   = 1'b1;
  localparam int   CYCLE_LIMIT = 6000000;
  localparam int   RANDOM_ITEMS = 600;
  localparam int   PHASES = 5;

  typedef struct {
    logic               kind;
    logic [4:0]         cx, cy, cz;
    logic               solid;
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
    logic [31:0]        reach;
  } vox_item_t;

  typedef struct {
    logic [1:0]        status;
    logic [4:0]        hx, hy, hz;
    logic signed [1:0] nx, ny, nz;
  } vox_result_t;

  // Ray caster predictor and store of expected results
  class ray_scoreboard;
    bit          occ[CELLS];
    bit [4:0]    scale;
    vox_result_t expected_q[$];
    int          errors, hits, misses, zeros, writes, checked;

    function new();
      scale = 5'd1;
      foreach (occ[i]) occ[i] = 1'b0;
    endfunction

    function bit solid_at(longint x, longint y, longint z);
      if (x < 0 || y < 0 || z < 0 || x >= GRID_SIZE || y >= GRID_SIZE || z >= GRID_SIZE)
        return 1'b0;
      return occ[x + GRID_SIZE * (y + GRID_SIZE * z)];
    endfunction

    function vox_result_t cast_ray(vox_item_t it);
      vox_result_t r;
      longint      d[3], org[3], adj, vc[3];
      int          stp[3];
      bit [63:0]   sumsq, tm[3], dl[3], f, a, rem, t;
      bit [127:0]  lhs, rhs;
      int          ax;
      r = '{default: '0};
      d[0] = it.dx; d[1] = it.dy; d[2] = it.dz;
      org[0] = it.ox; org[1] = it.oy; org[2] = it.oz;
      sumsq = 0;
      for (int i = 0; i < 3; i++) sumsq += 64'(d[i] * d[i]);
      if (sumsq == 0) begin
        r.status = ST_ZERO;
        return r;
      end
      // axis setup: start cell, first boundary and per-cell increment
      for (int i = 0; i < 3; i++) begin
        adj = org[i] * longint'({59'd0, scale});
        vc[i] = adj >>> 16;
        f = 64'(adj[15:0]);
        if (d[i] == 0) begin
          stp[i] = 0;
          tm[i] = 64'(SAT);
          dl[i] = 64'(SAT);
        end else begin
          if (d[i] > 0) begin
            stp[i] = 1;
            a = 64'(d[i]);
            rem = 64'd65536 - f;
          end else begin
            stp[i] = -1;
            a = 64'(-d[i]);
            rem = (f != 0) ? f : 64'd65536;
          end
          t = rem * 64'd16384 / a;
          tm[i] = (t > 64'(SAT)) ? 64'(SAT) : t;
          t = (64'd1 << 30) / a;
          dl[i] = (t > 64'(SAT)) ? 64'(SAT) : t;
        end
      end
      r.status = ST_MISS;
      // step across the nearest boundary, z wins ties over x and y, y over x
      for (int n = 0; n < MAX_STEPS; n++) begin
        if (tm[0] < tm[1]) ax = (tm[0] < tm[2]) ? 0 : 2;
        else ax = (tm[1] < tm[2]) ? 1 : 2;
        lhs = 128'(tm[ax]) * 128'(tm[ax]);
        lhs = lhs * 128'(sumsq);
        rhs = 128'(it.reach) << 14;
        rhs = rhs * rhs;
        if (lhs > rhs) break;
        vc[ax] += stp[ax];
        t = tm[ax] + dl[ax];
        tm[ax] = (t > 64'(SAT)) ? 64'(SAT) : t;
        if (solid_at(vc[0], vc[1], vc[2])) begin
          r.status = ST_HIT;
          r.hx = vc[0][4:0];
          r.hy = vc[1][4:0];
          r.hz = vc[2][4:0];
          if (ax == 0) r.nx = 2'(-stp[0]);
          if (ax == 1) r.ny = 2'(-stp[1]);
          if (ax == 2) r.nz = 2'(-stp[2]);
          break;
        end
      end
      return r;
    endfunction

    // note an accepted item and queue its expected result
    function void note_item(vox_item_t it);
      vox_result_t r;
      if (it.kind == KIND_WRITE) begin
        occ[it.cx + GRID_SIZE * (it.cy + GRID_SIZE * it.cz)] = it.solid;
        r = '{default: '0};
        r.status = ST_WRITE;
        writes++;
      end else begin
        r = cast_ray(it);
        if (r.status == ST_HIT) hits++;
        else if (r.status == ST_MISS) misses++;
        else zeros++;
      end
      expected_q.push_back(r);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(vox_result_t got);
      vox_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.hx !== e.hx || got.hy !== e.hy || got.hz !== e.hz) begin
        $display("%0t: hit cell expected (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
                 e.hx, e.hy, e.hz, got.hx, got.hy, got.hz);
        errors++;
      end
      if (got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz) begin
        $display("%0t: normal expected (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
                 e.nx, e.ny, e.nz, got.nx, got.ny, got.nz);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [4:0] cfg_wdata;
  vgrt_in_if  in_ch ();
  vgrt_out_if out_ch ();

  voxel_grid_ray_traversal u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  ray_scoreboard sb;
  logic in_rdy_s, out_vld_s;
  int   cycles;
  int   hold_req;
  bit   calm;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // sample handshakes mid-cycle, away from the driving edge
  always @(negedge clk) begin
    in_rdy_s  <= in_ch.ready;
    out_vld_s <= out_ch.valid;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // note accepted items
  always @(posedge clk) begin
    vox_item_t it;
    if (!rst && in_ch.valid && in_rdy_s) begin
      it.kind = in_ch.kind;
      it.cx = in_ch.cell_x; it.cy = in_ch.cell_y; it.cz = in_ch.cell_z;
      it.solid = in_ch.solid;
      it.ox = in_ch.origin_x; it.oy = in_ch.origin_y; it.oz = in_ch.origin_z;
      it.dx = in_ch.dir_x; it.dy = in_ch.dir_y; it.dz = in_ch.dir_z;
      it.reach = in_ch.reach;
      sb.note_item(it);
    end
  end

  // check accepted results
  always @(posedge clk) begin
    vox_result_t got;
    if (!rst && out_vld_s && out_ch.ready) begin
      got.status = out_ch.status;
      got.hx = out_ch.hit_x; got.hy = out_ch.hit_y; got.hz = out_ch.hit_z;
      got.nx = out_ch.normal_x; got.ny = out_ch.normal_y; got.nz = out_ch.normal_z;
      sb.check_result(got);
    end
  end

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // result side: random stalls, plus one long hold on request
  int hold_cnt;
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      hold_cnt = pick_gap();
      out_ch.ready <= (hold_cnt == 0);
    end
  end

  task automatic send_item(vox_item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.kind <= it.kind;
    in_ch.cell_x <= it.cx; in_ch.cell_y <= it.cy; in_ch.cell_z <= it.cz;
    in_ch.solid <= it.solid;
    in_ch.origin_x <= it.ox; in_ch.origin_y <= it.oy; in_ch.origin_z <= it.oz;
    in_ch.dir_x <= it.dx; in_ch.dir_y <= it.dy; in_ch.dir_z <= it.dz;
    in_ch.reach <= it.reach;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_rdy_s) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(logic [4:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.scale = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic vox_item_t cell_write(int x, int y, int z, bit s);
    vox_item_t it;
    it = '{default: '0};
    it.kind = KIND_WRITE;
    it.cx = 5'(x); it.cy = 5'(y); it.cz = 5'(z);
    it.solid = s;
    return it;
  endfunction

  function automatic vox_item_t ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    logic [31:0] reach);
    vox_item_t it;
    it = '{default: '0};
    it.kind = KIND_RAY;
    it.ox = ox; it.oy = oy; it.oz = oz;
    it.dx = 16'(dx); it.dy = 16'(dy); it.dz = 16'(dz);
    it.reach = reach;
    return it;
  endfunction

  function automatic logic signed [15:0] rand_dir();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'sd0;
    if (r < 3) return 16'($urandom());
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // random item: writes mostly into a dense box, rays mostly short and inside the grid
  function automatic vox_item_t rand_item();
    vox_item_t it;
    int span, r;
    it = '{default: '0};
    r = $urandom_range(0, 99);
    if (r < 30) begin
      if ($urandom_range(0, 9) < 7)
        it = cell_write($urandom_range(10, 21), $urandom_range(10, 21),
                        $urandom_range(10, 21), $urandom_range(0, 9) < 7);
      else
        it = cell_write($urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 1));
      it.ox = $urandom(); it.dx = 16'($urandom()); it.reach = $urandom();
      return it;
    end
    it.kind = KIND_RAY;
    if (r < 36) begin
      // full-range noise on every field
      it.ox = $urandom(); it.oy = $urandom(); it.oz = $urandom();
      it.dx = 16'($urandom()); it.dy = 16'($urandom()); it.dz = 16'($urandom());
      it.reach = $urandom();
    end else begin
      span = (sb.scale == 0) ? (32 << 16) : ((36 << 16) / sb.scale);
      it.ox = $urandom_range(0, span) - (span / 16);
      it.oy = $urandom_range(0, span) - (span / 16);
      it.oz = $urandom_range(0, span) - (span / 16);
      it.dx = rand_dir(); it.dy = rand_dir(); it.dz = rand_dir();
      it.reach = $urandom_range(0, 40 << 16);
    end
    it.cx = 5'($urandom()); it.cy = 5'($urandom()); it.cz = 5'($urandom());
    it.solid = 1'($urandom());
    return it;
  endfunction

  initial begin
    logic [4:0] scales[PHASES];
    sb = new();
    cycles = 0;
    hold_req = 0;
    hold_cnt = 0;
    calm = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 5'd0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.cell_x = '0; in_ch.cell_y = '0; in_ch.cell_z = '0; in_ch.solid = 1'b0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0; in_ch.reach = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corner writes, zero direction, axis rays, ties, step limit, extremes
    write_scale(5'd1);
    send_item(cell_write(0, 0, 0, 1'b1));
    send_item(cell_write(31, 31, 31, 1'b1));
    send_item(cell_write(5, 5, 5, 1'b1));
    send_item(cell_write(2, 2, 3, 1'b1));
    send_item(ray(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(ray(32'sh0005_8000, 32'sh0005_8000, 32'sh0002_8000, 0, 0, 16384, 10 << 16));
    send_item(ray(32'sh0005_8000, 32'sh0005_8000, 32'sh0008_8000, 0, 0, -16384, 10 << 16));
    send_item(ray(32'sh0008_8000, 32'sh0005_8000, 32'sh0005_8000, -32768, 0, 0, 10 << 16));
    send_item(ray(32'sh0002_8000, 32'sh0002_8000, 32'sh0002_8000, 8192, 8192, 8192,
                  8 << 16));
    send_item(ray(32'sh0001_8000, 32'sh0001_8000, 32'sh0001_8000, -8192, -8192, -8192,
                  8 << 16));
    send_item(ray(32'sh001E_8000, 32'sh001E_8000, 32'sh001E_8000, 32767, 32767, 32767,
                  8 << 16));
    send_item(ray(32'sh0005_8000, 32'sh0005_8000, 32'sh0002_8000, 0, 0, 16384, 0));
    send_item(ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 1, -1, 0, 32'hFFFF_FFFF));
    send_item(ray(-(40 << 16), 0, 0, -16384, 3, 0, 32'hFFFF_FFFF));
    send_item(ray(32'sh0002_0000, 32'sh0002_0000, 32'sh0000_0000, 0, 0, -1, 32'hFFFF_FFFF));
    send_item(cell_write(0, 0, 0, 1'b0));
    send_item(cell_write(31, 31, 31, 1'b0));
    send_item(ray(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -16384, -16384, -16384,
                  4 << 16));
    drain();
    write_scale(5'd0);
    send_item(ray(32'sh1234_5678, 32'sh7654_3210, 32'shFFFF_0000, 16384, 0, 0, 2 << 16));
    drain();

    scales = '{5'd1, 5'd16, 5'd31, 5'd0, 5'($urandom_range(2, 15))};
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_scale(scales[p]);
      calm = (p == 3);
      if (p == 1) hold_req = 4000;
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        send_item(rand_item());
        if (p == 2 && i == 60) drain();
      end
    end
    drain();
    repeat (100) @(posedge clk);

    $display("Run: %0d cell writes, %0d hits, %0d misses, %0d zero-direction rays checked.",
             sb.writes, sb.hits, sb.misses, sb.zeros);
    $display("Scales 0, 1, 16, 31 and one mid value exercised; %0d results compared.",
             sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
